// ===== design/mlt_pkg.sv =====
// Shared types and constants for the MAC learning table.
`default_nettype none
package mlt_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int MAX_PROBE_DEF = 8;

  localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME     = 32'd16777619;
  localparam logic [47:0] TIMEOUT_RESET = 48'd300000000000;

  localparam logic ACT_LEARN  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        action;
    logic [47:0] mac_addr;
    logic [15:0] learn_port;
    logic [47:0] now_ticks;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] found_port;
    logic [31:0] full_count;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] addr;
    logic [15:0] port;
    logic [47:0] seen;
  } entry_t;

endpackage
`default_nettype wire

// ===== design/mac_learning_table_core.sv =====
// MAC learning table: FNV-1a hashed, linearly probed, aging entries.
//
//   channel  signals                      payload
//   in       in_valid / in_ready          in_data  (mlt_pkg::in_t)
//   out      out_valid / out_ready        out_data (mlt_pkg::out_t)
//   cfg      cfg_valid / cfg_ready        cfg_data (aging_timeout, 48 bits)
//
// One transaction at a time: hash of the six address bytes (one shared 32x32 multiply per
// byte), bitwise remainder when CAPACITY is not a power of two, table read, probes
// (1..MAX_PROBE), then the result is posted and the core returns to idle to accept
// the next transaction.
// After reset every slot of the table is cleared; in_ready stays low during the sweep.
// A result waiting on out_ready does not block acceptance of the next input transaction, but that one waits to post.
`default_nettype none
module mac_learning_table_core #(
  parameter int CAPACITY  = mlt_pkg::CAPACITY_DEF,
  parameter int MAX_PROBE = mlt_pkg::MAX_PROBE_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire mlt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output mlt_pkg::out_t      out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire         [47:0] cfg_data
);

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PROBE_W = $clog2(MAX_PROBE + 1);
  localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam logic [IDX_W-1:0]   LAST_SLOT  = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]     CAP_W      = (IDX_W + 1)'(CAPACITY);
  localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(MAX_PROBE - 1);

  mlt_pkg::state_t state, state_next;
  mlt_pkg::in_t    item;
  mlt_pkg::entry_t mem [CAPACITY];
  mlt_pkg::entry_t rd_q;
  mlt_pkg::entry_t mem_wdata;
  mlt_pkg::out_t   out_data_next;

  logic [31:0]        hash, hash_next;
  logic [2:0]         byte_idx, byte_idx_next;
  logic [4:0]         bit_cnt, bit_cnt_next;
  logic [IDX_W-1:0]   rem, rem_next;
  logic [IDX_W-1:0]   slot, slot_next, slot_inc;
  logic [PROBE_W-1:0] probe, probe_next;
  logic               res_ok, res_ok_next;
  logic [15:0]        res_port, res_port_next;
  logic [31:0]        fail_counter, fail_counter_next;
  logic               out_valid_next;
  logic [47:0]        aging_timeout;

  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [7:0]         hash_byte;
  logic [IDX_W:0]     trial;
  logic [47:0]        age;
  logic               expired, addr_match, is_last;

  assign in_ready  = (state == mlt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign slot_inc   = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign hash_byte  = 8'(item.mac_addr >> {byte_idx, 3'b000});
  assign trial      = {rem, hash[31]};
  assign age        = 48'(item.now_ticks - rd_q.seen);
  assign expired    = age > aging_timeout;
  assign addr_match = (rd_q.addr == item.mac_addr);
  assign is_last    = (probe == LAST_PROBE);

  always_comb begin
    state_next        = state;
    hash_next         = hash;
    byte_idx_next     = byte_idx;
    bit_cnt_next      = bit_cnt;
    rem_next          = rem;
    slot_next         = slot;
    probe_next        = probe;
    res_ok_next       = res_ok;
    res_port_next     = res_port;
    fail_counter_next = fail_counter;
    out_valid_next    = out_valid && !out_ready;
    out_data_next     = out_data;
    mem_we            = 1'b0;
    mem_waddr         = slot;
    mem_wdata         = '0;
    mem_re            = 1'b0;
    mem_raddr         = slot;
    unique case (state)
      mlt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        slot_next = slot_inc;
        if (slot == LAST_SLOT) begin
          state_next = mlt_pkg::ST_IDLE;
        end
      end
      mlt_pkg::ST_IDLE: begin
        if (in_valid) begin
          hash_next     = mlt_pkg::FNV_BASIS;
          byte_idx_next = 3'd5;
          state_next    = mlt_pkg::ST_HASH;
        end
      end
      mlt_pkg::ST_HASH: begin
        hash_next     = 32'((hash ^ {24'b0, hash_byte}) * mlt_pkg::FNV_PRIME);
        byte_idx_next = byte_idx - 3'd1;
        if (byte_idx == 3'd0) begin
          rem_next     = '0;
          bit_cnt_next = 5'd31;
          slot_next    = hash_next[IDX_W-1:0];
          state_next   = IS_POW2 ? mlt_pkg::ST_READ : mlt_pkg::ST_MOD;
        end
      end
      mlt_pkg::ST_MOD: begin
        rem_next     = (trial >= CAP_W) ? IDX_W'(trial - CAP_W) : trial[IDX_W-1:0];
        hash_next    = {hash[30:0], 1'b0};
        bit_cnt_next = bit_cnt - 5'd1;
        if (bit_cnt == 5'd0) begin
          slot_next  = rem_next;
          state_next = mlt_pkg::ST_READ;
        end
      end
      mlt_pkg::ST_READ: begin
        mem_re     = 1'b1;
        probe_next = '0;
        state_next = mlt_pkg::ST_CHECK;
      end
      mlt_pkg::ST_CHECK: begin
        res_ok_next   = 1'b0;
        res_port_next = '0;
        if (item.action == mlt_pkg::ACT_LEARN) begin
          if (!rd_q.valid || expired || addr_match) begin
            mem_we      = 1'b1;
            mem_wdata   = '{valid: 1'b1, addr: item.mac_addr,
                            port: item.learn_port, seen: item.now_ticks};
            res_ok_next = 1'b1;
            state_next  = mlt_pkg::ST_DONE;
          end else if (is_last) begin
            fail_counter_next = fail_counter + 32'd1;
            state_next        = mlt_pkg::ST_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = slot_inc;
            slot_next  = slot_inc;
            probe_next = probe + 1'b1;
          end
        end else begin
          if (!rd_q.valid) begin
            state_next = mlt_pkg::ST_DONE;
          end else if (addr_match) begin
            if (expired) begin
              mem_we          = 1'b1;
              mem_wdata       = rd_q;
              mem_wdata.valid = 1'b0;
            end else begin
              res_ok_next   = 1'b1;
              res_port_next = rd_q.port;
            end
            state_next = mlt_pkg::ST_DONE;
          end else if (is_last) begin
            state_next = mlt_pkg::ST_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = slot_inc;
            slot_next  = slot_inc;
            probe_next = probe + 1'b1;
          end
        end
      end
      mlt_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_data_next  = '{ok: res_ok, found_port: res_port, full_count: fail_counter};
          state_next     = mlt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mlt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mlt_pkg::ST_CLEAR;
      slot          <= '0;
      fail_counter  <= '0;
      out_valid     <= 1'b0;
      aging_timeout <= mlt_pkg::TIMEOUT_RESET;
    end else begin
      state        <= state_next;
      slot         <= slot_next;
      fail_counter <= fail_counter_next;
      out_valid    <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        aging_timeout <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    hash     <= hash_next;
    byte_idx <= byte_idx_next;
    bit_cnt  <= bit_cnt_next;
    rem      <= rem_next;
    probe    <= probe_next;
    res_ok   <= res_ok_next;
    res_port <= res_port_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  a_miss_port_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.ok) |-> (out_data.found_port == 16'd0))
    else $error("miss or failed learn carries a port");

  a_fail_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fail_counter != $past(fail_counter))
      |-> (fail_counter == $past(fail_counter) + 32'd1))
    else $error("failure counter moved by more than one");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == mlt_pkg::ST_CLEAR || state == mlt_pkg::ST_CHECK))
    else $error("table write outside sweep or probe");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mlt_pkg::ST_CHECK) |-> (probe <= LAST_PROBE))
    else $error("probe count past bound");

endmodule
`default_nettype wire

// ===== tb/mac_learning_table_core_tb.sv =====
// Self-checking testbench for the MAC learning table core.
`timescale 1ns / 100ps
`default_nettype none
module mac_learning_table_core_tb;

  localparam int          CAP        = mlt_pkg::CAPACITY_DEF;
  localparam int          PROBES     = mlt_pkg::MAX_PROBE_DEF;
  localparam int          HOT_N      = 24;
  localparam int          WIDE_N     = 48;
  localparam int          PHASE_N    = 6;
  localparam int          PHASE_ITEMS = 140;
  localparam int          STALL_LIMIT = 20000;
  localparam logic [47:0] ALL48      = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] PAT48      = 48'hA5A5_A5A5_A5A5;

  typedef struct {
    logic          act;
    int            pool;
    logic [47:0]   addr;
    logic [15:0]   port;
    logic [47:0]   stamp;
    bit            typed;
    mlt_pkg::out_t want;
  } row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  mlt_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  mlt_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic   [47:0] cfg_data;

  // mirror of the table
  bit          tbl_valid [CAP];
  logic [47:0] tbl_addr  [CAP];
  logic [15:0] tbl_port  [CAP];
  logic [47:0] tbl_seen  [CAP];
  logic [31:0] refused_learns;
  logic [47:0] aging_limit;

  mlt_pkg::out_t replies_due[$];
  logic [47:0]   hot_addrs  [HOT_N];
  logic [47:0]   wide_addrs [WIDE_N];
  row_t          dir_rows   [25];

  int  errors;
  int  checked;
  int  n_learn, n_lookup, n_hit, n_aged;
  bit  in_calm;
  bit  out_calm;

  mac_learning_table_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int home_slot(logic [47:0] a);
    logic [31:0] h;
    h = mlt_pkg::FNV_BASIS;
    for (int b = 5; b >= 0; b--) begin
      h = h ^ {24'd0, a[b*8 +: 8]};
      h = h * mlt_pkg::FNV_PRIME;
    end
    return int'(h % CAP);
  endfunction

  function automatic bit aged_out(int s, logic [47:0] stamp);
    logic [47:0] age;
    age = stamp - tbl_seen[s];
    return age > aging_limit;
  endfunction

  // learn or lookup against the mirror; returns the reply the core must post
  function automatic mlt_pkg::out_t apply_table_op(mlt_pkg::in_t d);
    mlt_pkg::out_t r;
    int            home;
    int            s;
    bit            done;
    r    = '0;
    home = home_slot(d.mac_addr);
    done = 1'b0;
    if (d.action == mlt_pkg::ACT_LEARN) begin
      n_learn++;
      for (int p = 0; p < PROBES && !done; p++) begin
        s = (home + p) % CAP;
        if (!tbl_valid[s] || aged_out(s, d.now_ticks) || tbl_addr[s] == d.mac_addr) begin
          tbl_valid[s] = 1'b1;
          tbl_addr[s]  = d.mac_addr;
          tbl_port[s]  = d.learn_port;
          tbl_seen[s]  = d.now_ticks;
          r.ok         = 1'b1;
          done         = 1'b1;
        end
      end
      if (!done) refused_learns = refused_learns + 32'd1;
    end else begin
      n_lookup++;
      for (int p = 0; p < PROBES && !done; p++) begin
        s = (home + p) % CAP;
        if (!tbl_valid[s]) begin
          done = 1'b1;
        end else if (tbl_addr[s] == d.mac_addr) begin
          done = 1'b1;
          if (aged_out(s, d.now_ticks)) begin
            tbl_valid[s] = 1'b0;
            n_aged++;
          end else begin
            r.ok         = 1'b1;
            r.found_port = tbl_port[s];
            n_hit++;
          end
        end
      end
    end
    r.full_count = refused_learns;
    return r;
  endfunction

  task automatic send_item(input mlt_pkg::in_t d, input bit typed, input mlt_pkg::out_t want);
    mlt_pkg::out_t p;
    int            gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = d;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    p = apply_table_op(d);
    replies_due.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic write_timeout(input logic [47:0] v);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    aging_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic report(input string what, input logic [47:0] want, input logic [47:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    mlt_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        report("unexpected transaction", 48'd0, 48'd1);
      end else begin
        e = replies_due.pop_front();
        checked++;
        if (out_data.ok !== e.ok) report("ok", 48'(e.ok), 48'(out_data.ok));
        if (out_data.found_port !== e.found_port)
          report("found_port", 48'(e.found_port), 48'(out_data.found_port));
        if (out_data.full_count !== e.full_count)
          report("full_count", 48'(e.full_count), 48'(out_data.full_count));
      end
    end
  end

  // receiver stalls
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    out_calm  = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    mlt_pkg::in_t d;
    row_t         row;
    logic [47:0]  stamp;
    logic [47:0]  tmo [PHASE_N];
    int           n;
    int           r;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_calm   = 1'b0;
    errors    = 0;
    checked   = 0;
    n_learn   = 0;
    n_lookup  = 0;
    n_hit     = 0;
    n_aged    = 0;
    refused_learns = '0;
    aging_limit    = mlt_pkg::TIMEOUT_RESET;
    for (int i = 0; i < CAP; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i]  = '0;
      tbl_port[i]  = '0;
      tbl_seen[i]  = '0;
    end

    // addresses hashing to the last four slots, so chains wrap to slot 0
    n = 0;
    while (n < HOT_N) begin
      hot_addrs[n] = rand48();
      if (home_slot(hot_addrs[n]) >= CAP - 4) n++;
    end
    for (int i = 0; i < WIDE_N; i++) wide_addrs[i] = rand48();

    dir_rows = '{
      '{mlt_pkg::ACT_LOOKUP, -1, 48'h0, 16'h0,    48'd0,   1'b1, '{1'b0, 16'h0,    32'd0}},
      '{mlt_pkg::ACT_LEARN,  -1, ALL48, 16'hFFFF, 48'd0,   1'b1, '{1'b1, 16'h0,    32'd0}},
      '{mlt_pkg::ACT_LOOKUP, -1, ALL48, 16'h0,    48'd100, 1'b1, '{1'b1, 16'hFFFF, 32'd0}},
      '{mlt_pkg::ACT_LOOKUP, -1, ALL48, 16'h0,    ALL48,   1'b1, '{1'b0, 16'h0,    32'd0}},
      '{mlt_pkg::ACT_LOOKUP, -1, ALL48, 16'h0,    48'd100, 1'b1, '{1'b0, 16'h0,    32'd0}},
      '{mlt_pkg::ACT_LEARN,  -1, 48'h0, 16'h0,    48'd0,   1'b1, '{1'b1, 16'h0,    32'd0}},
      '{mlt_pkg::ACT_LEARN,  -1, 48'h0, 16'd1234, 48'd5,   1'b1, '{1'b1, 16'h0,    32'd0}},
      '{mlt_pkg::ACT_LOOKUP, -1, 48'h0, 16'hFFFF, 48'd6,   1'b1, '{1'b1, 16'd1234, 32'd0}},
      '{mlt_pkg::ACT_LEARN,  -1, PAT48, 16'h5A5A, ALL48,   1'b1, '{1'b1, 16'h0,    32'd0}},
      '{mlt_pkg::ACT_LOOKUP, -1, PAT48, 16'h0,    48'd10,  1'b1, '{1'b1, 16'h5A5A, 32'd0}},
      '{mlt_pkg::ACT_LEARN,  0,  48'h0, 16'h0100, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  1,  48'h0, 16'h0101, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  2,  48'h0, 16'h0102, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  3,  48'h0, 16'h0103, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  4,  48'h0, 16'h0104, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  5,  48'h0, 16'h0105, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  6,  48'h0, 16'h0106, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  7,  48'h0, 16'h0107, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  8,  48'h0, 16'h0108, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  9,  48'h0, 16'h0109, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  10, 48'h0, 16'h010A, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  11, 48'h0, 16'h010B, 48'd1000, 1'b0, '0},
      '{mlt_pkg::ACT_LOOKUP, 11, 48'h0, 16'h0,    48'd1001, 1'b0, '0},
      '{mlt_pkg::ACT_LEARN,  0,  48'h0, 16'h0200, 48'd300000001001, 1'b0, '0},
      '{mlt_pkg::ACT_LOOKUP, 5,  48'h0, 16'h0,    48'd400000001000, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      row          = dir_rows[i];
      d.action     = row.act;
      d.mac_addr   = (row.pool < 0) ? row.addr : hot_addrs[row.pool];
      d.learn_port = row.port;
      d.now_ticks  = row.stamp;
      send_item(d, row.typed, row.want);
    end

    tmo[0] = 48'd0;
    tmo[1] = ALL48;
    tmo[2] = 48'($urandom_range(20, 200));
    tmo[3] = mlt_pkg::TIMEOUT_RESET;
    tmo[4] = 48'($urandom_range(20, 200));
    tmo[5] = rand48();
    stamp  = rand48();

    for (int ph = 0; ph < PHASE_N; ph++) begin
      write_timeout(tmo[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        r = $urandom_range(0, 99);
        if (r < 55)
          d.mac_addr = hot_addrs[$urandom_range(0, HOT_N - 1)];
        else if (r < 90)
          d.mac_addr = wide_addrs[$urandom_range(0, WIDE_N - 1)];
        else if (r < 92)
          d.mac_addr = '0;
        else if (r < 94)
          d.mac_addr = ALL48;
        else
          d.mac_addr = rand48();
        d.action     = ($urandom_range(0, 99) < 45) ? mlt_pkg::ACT_LEARN : mlt_pkg::ACT_LOOKUP;
        d.learn_port = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 85)
          stamp = stamp + 48'($urandom_range(0, 30));
        else if (r < 93)
          stamp = stamp + rand48();
        else if (r < 97)
          stamp = stamp - 48'($urandom_range(1, 50));
        else
          stamp = rand48();
        d.now_ticks = stamp;
        send_item(d, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Covered %0d learns (%0d refused on a full chain) and %0d lookups", n_learn,
             refused_learns, n_lookup);
    $display("with %0d hits and %0d aged entries over %0d timeout settings; %0d replies checked",
             n_hit, n_aged, PHASE_N + 1, checked);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/mlt_pkg.sv
design/mac_learning_table_core.sv
tb/mac_learning_table_core_tb.sv
